// ===== sv/fmqf_pkg.sv =====
// ============================================================================
// fmqf_pkg: shared types and constants of the frequency matching quad filter
// Field widths, register indexes, pairing codes and parameter defaults.
// ============================================================================
package fmqf_pkg;

  // Parameter defaults for the top level.
  localparam int unsigned NUM_MODES_DEF = 1024;
  localparam int unsigned FREQ_BITS_DEF = 16;

  // Fixed field widths of the stream payloads.
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LOAD_W     = 16;
  localparam int unsigned TOL_W      = 17;
  localparam int unsigned PAIR_W     = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_TOLERANCE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EQUAL_SHORTCUT  = 1'b1;

  // Kind of an input item.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  // Ordering of an emitted quadruplet.
  typedef enum logic [PAIR_W-1:0] {
    PAIR_ABCD = 2'd0,
    PAIR_ADCB = 2'd1,
    PAIR_ACBD = 2'd2
  } pair_t;

  // Four mode indices of one quadruplet.
  typedef struct packed {
    logic [IDX_W-1:0] d;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] a;
  } quad_t;

endpackage

// ===== sv/fmqf_ram.sv =====
// ============================================================================
// fmqf_ram: generic single-write, single-read RAM
// One write port and one read port whose data is registered on read enable.
// ============================================================================
module fmqf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/frequency_matching_quad_filter.sv =====
// ============================================================================
// frequency_matching_quad_filter: quadruplet filter on a mode frequency table
// Loads a frequency table and, for each checked quadruplet, emits every
// pairing whose frequency mismatch stays within the tolerance.
// ============================================================================
//
//  Channel  Direction  Carries
//  in_*     input      load (index, value) or check (four mode indices)
//  out_*    output     one accepted ordering, pairing code, last marker
//  cfg_*    input      register writes: match tolerance, equal shortcut
//
//  A check passes five register stages: table read, pair sums, absolute
//  mismatches, tolerance compare, and the result register that sends one
//  result per cycle while out_tready is high. A new item is taken every
//  cycle while items give at most one result and out_tready stays high; an
//  item with several results holds the result register until all of them
//  are sent, which stalls the stages behind it. Loads write the table at
//  the transfer edge and give no result. Reset (rst_n low, synchronous)
//  empties every stage and clears both registers; the table is undefined
//  until written. A stall on out_tready backs up stage by stage and drops
//  in_tready only when all stages are full.
// ============================================================================
module frequency_matching_quad_filter #(
  parameter int unsigned NUM_MODES = fmqf_pkg::NUM_MODES_DEF,
  parameter int unsigned FREQ_BITS = fmqf_pkg::FREQ_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: load_index, load_value, mode_a, mode_b, mode_c, mode_d, zeros
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fmqf_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: operation
  input  logic                                in_tuser,
  // out_tdata: out_first, out_second, out_third, out_fourth
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fmqf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: pairing
  output logic [fmqf_pkg::PAIR_W-1:0]         out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [fmqf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fmqf_pkg::TOL_W-1:0]          cfg_wdata
);

  localparam int unsigned ADDR_W = $clog2(NUM_MODES);
  localparam int unsigned SUM_W  = FREQ_BITS + 1;
  localparam int unsigned MIS_W  = (SUM_W > fmqf_pkg::TOL_W) ? SUM_W : fmqf_pkg::TOL_W;
  localparam int unsigned IW     = fmqf_pkg::IDX_W;

  // Configuration registers.
  logic [fmqf_pkg::TOL_W-1:0] tol_r;
  logic                       eq_en_r;

  // Input field split.
  logic [IW-1:0]                 load_index;
  logic [fmqf_pkg::LOAD_W-1:0]   load_value;
  fmqf_pkg::quad_t               in_quad;
  logic                          in_xfer;
  logic                          in_check;
  logic                          load_inr;
  logic [3:0]                    quad_inr;
  logic [ADDR_W-1:0]             rd_addr [4];

  // Stage 1: table read.
  logic                  s1_v_r;
  fmqf_pkg::quad_t       s1_quad_r;
  logic [3:0]            s1_inr_r;
  logic [FREQ_BITS-1:0]  ram_q [4];
  logic [FREQ_BITS-1:0]  f_sel [4];

  // Stage 2: pair sums.
  logic                  s2_v_r;
  fmqf_pkg::quad_t       s2_quad_r;
  logic                  s2_eq_r;
  logic [SUM_W-1:0]      s2_ab_r, s2_cd_r, s2_ad_r, s2_cb_r, s2_ac_r, s2_bd_r;

  // Stage 3: absolute mismatches.
  logic                  s3_v_r;
  fmqf_pkg::quad_t       s3_quad_r;
  logic                  s3_eq_r;
  logic [SUM_W-1:0]      s3_m0_r, s3_m1_r, s3_m2_r;

  // Stage 4: pass mask.
  logic                  s4_v_r;
  fmqf_pkg::quad_t       s4_quad_r;
  logic [2:0]            s4_mask_r;
  logic [2:0]            s4_mask_nxt;

  // Result register.
  logic [2:0]            ser_mask_r;
  logic [2:0]            ser_mask_nxt;
  fmqf_pkg::quad_t       ser_quad_r;
  logic                  ser_single;
  logic                  ser_free;
  logic                  out_xfer;
  fmqf_pkg::pair_t       cur_pair;

  // Stage handshakes.
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // Absolute difference of two sums.
  function automatic logic [SUM_W-1:0] abs_diff(input logic [SUM_W-1:0] x,
                                                input logic [SUM_W-1:0] y);
    logic [SUM_W:0] dxy;
    logic [SUM_W:0] dyx;
    dxy = {1'b0, x} - {1'b0, y};
    dyx = {1'b0, y} - {1'b0, x};
    return dxy[SUM_W] ? dyx[SUM_W-1:0] : dxy[SUM_W-1:0];
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= '0;
      eq_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        fmqf_pkg::CFG_MATCH_TOLERANCE: tol_r   <= cfg_wdata;
        fmqf_pkg::CFG_EQUAL_SHORTCUT:  eq_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input unpacking and index range checks.
  assign load_index = in_tdata[IW-1:0];
  assign load_value = in_tdata[IW+fmqf_pkg::LOAD_W-1:IW];
  assign in_quad    = in_tdata[IW+fmqf_pkg::LOAD_W+4*IW-1:IW+fmqf_pkg::LOAD_W];
  assign in_xfer    = in_tvalid && in_tready;
  assign in_check   = (in_tuser == fmqf_pkg::OP_CHECK);
  assign load_inr   = 32'(load_index) < 32'(NUM_MODES);

  always_comb begin
    quad_inr[0] = 32'(in_quad.a) < 32'(NUM_MODES);
    quad_inr[1] = 32'(in_quad.b) < 32'(NUM_MODES);
    quad_inr[2] = 32'(in_quad.c) < 32'(NUM_MODES);
    quad_inr[3] = 32'(in_quad.d) < 32'(NUM_MODES);
    rd_addr[0]  = ADDR_W'(in_quad.a);
    rd_addr[1]  = ADDR_W'(in_quad.b);
    rd_addr[2]  = ADDR_W'(in_quad.c);
    rd_addr[3]  = ADDR_W'(in_quad.d);
  end

  // Four table copies, each written by every in-range load, one read each.
  for (genvar g = 0; g < 4; g++) begin : g_table
    fmqf_ram #(
      .WIDTH (FREQ_BITS),
      .DEPTH (NUM_MODES)
    ) u_ram (
      .clk   (clk),
      .we    (in_xfer && !in_check && load_inr),
      .waddr (ADDR_W'(load_index)),
      .wdata (FREQ_BITS'(load_value)),
      .re    (in_xfer && in_check),
      .raddr (rd_addr[g]),
      .rdata (ram_q[g])
    );
  end

  // Backward ready chain.
  assign s4_ready  = !s4_v_r || ser_free;
  assign s3_ready  = !s3_v_r || s4_ready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;

  // Stage 1 control and side data; the RAM output is the frequency register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_xfer && in_check;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_check) begin
      s1_quad_r <= in_quad;
      s1_inr_r  <= quad_inr;
    end
  end

  // Out of range indices read as frequency zero.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      f_sel[i] = s1_inr_r[i] ? ram_q[i] : '0;
    end
  end

  // Stage 2: the six pair sums and the all-equal flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      s2_quad_r <= s1_quad_r;
      s2_eq_r   <= (f_sel[0] == f_sel[1]) && (f_sel[0] == f_sel[2]) &&
                   (f_sel[0] == f_sel[3]);
      s2_ab_r   <= SUM_W'(f_sel[0]) + SUM_W'(f_sel[1]);
      s2_cd_r   <= SUM_W'(f_sel[2]) + SUM_W'(f_sel[3]);
      s2_ad_r   <= SUM_W'(f_sel[0]) + SUM_W'(f_sel[3]);
      s2_cb_r   <= SUM_W'(f_sel[2]) + SUM_W'(f_sel[1]);
      s2_ac_r   <= SUM_W'(f_sel[0]) + SUM_W'(f_sel[2]);
      s2_bd_r   <= SUM_W'(f_sel[1]) + SUM_W'(f_sel[3]);
    end
  end

  // Stage 3: absolute mismatch of each pairing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_ready) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_v_r) begin
      s3_quad_r <= s2_quad_r;
      s3_eq_r   <= s2_eq_r;
      s3_m0_r   <= abs_diff(s2_ab_r, s2_cd_r);
      s3_m1_r   <= abs_diff(s2_ad_r, s2_cb_r);
      s3_m2_r   <= abs_diff(s2_ac_r, s2_bd_r);
    end
  end

  // Stage 4: tolerance compare; the equal shortcut keeps only the original order.
  always_comb begin
    if (eq_en_r && s3_eq_r) begin
      s4_mask_nxt = 3'b001;
    end else begin
      s4_mask_nxt[0] = MIS_W'(s3_m0_r) <= MIS_W'(tol_r);
      s4_mask_nxt[1] = MIS_W'(s3_m1_r) <= MIS_W'(tol_r);
      s4_mask_nxt[2] = MIS_W'(s3_m2_r) <= MIS_W'(tol_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_ready) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_v_r) begin
      s4_quad_r <= s3_quad_r;
      s4_mask_r <= s4_mask_nxt;
    end
  end

  // Result register: sends the pending pairings lowest first.
  assign ser_single = (ser_mask_r != 3'b000) && ((ser_mask_r & (ser_mask_r - 3'd1)) == 3'b000);
  assign out_xfer   = out_tvalid && out_tready;
  assign ser_free   = (ser_mask_r == 3'b000) || (out_xfer && ser_single);

  always_comb begin
    if (ser_free) begin
      ser_mask_nxt = s4_v_r ? s4_mask_r : 3'b000;
    end else if (out_xfer) begin
      ser_mask_nxt = ser_mask_r & (ser_mask_r - 3'd1);
    end else begin
      ser_mask_nxt = ser_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_mask_r <= 3'b000;
    end else begin
      ser_mask_r <= ser_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_free && s4_v_r) begin
      ser_quad_r <= s4_quad_r;
    end
  end

  // Output ordering for the current pairing.
  always_comb begin
    if (ser_mask_r[0]) begin
      cur_pair = fmqf_pkg::PAIR_ABCD;
    end else if (ser_mask_r[1]) begin
      cur_pair = fmqf_pkg::PAIR_ADCB;
    end else begin
      cur_pair = fmqf_pkg::PAIR_ACBD;
    end
  end

  always_comb begin
    case (cur_pair)
      fmqf_pkg::PAIR_ABCD: out_tdata = {ser_quad_r.d, ser_quad_r.c, ser_quad_r.b, ser_quad_r.a};
      fmqf_pkg::PAIR_ADCB: out_tdata = {ser_quad_r.b, ser_quad_r.c, ser_quad_r.d, ser_quad_r.a};
      fmqf_pkg::PAIR_ACBD: out_tdata = {ser_quad_r.d, ser_quad_r.b, ser_quad_r.c, ser_quad_r.a};
      default:             out_tdata = {ser_quad_r.d, ser_quad_r.c, ser_quad_r.b, ser_quad_r.a};
    endcase
  end

  assign out_tvalid = (ser_mask_r != 3'b000);
  assign out_tuser  = cur_pair;
  assign out_tlast  = ser_single;

  // Input backpressure only when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && (ser_mask_r != 3'b000)))
    else $error("input stalled with an empty pipeline stage");

  // An all-equal quadruplet under the shortcut yields a single result.
  a_shortcut_single: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && s4_ready && eq_en_r && s3_eq_r) |=> (s4_v_r && (s4_mask_r == 3'b001)))
    else $error("equal shortcut gave more than the original order");

  // A stalled stage-1 item keeps its frequencies in the first and fourth copies.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(ram_q[0]) && $stable(ram_q[3])))
    else $error("stage 1 lost its item under a stall");

  // The final result of an item with nothing queued behind it empties the output.
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast && !s4_v_r) |=> !out_tvalid)
    else $error("result repeated after its last transfer");

endmodule

// ===== tb/quad_filter_checker.sv =====
// ============================================================================
// quad_filter_checker: result checker for the frequency matching quad filter
// Watches the input, result and register channels of the filter. It keeps
// its own copy of the frequency table and the registers, works out the
// accepted orderings of every checked quadruplet and compares each result
// transfer, field by field, with the oldest awaited ordering.
// ============================================================================
module quad_filter_checker
  import fmqf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [PAIR_W-1:0]     out_tuser,
  input  logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TOL_W-1:0]      cfg_wdata,
  output int unsigned           error_count,
  output int unsigned           outstanding
);

  // One accepted ordering as the filter should send it.
  typedef struct packed {
    quad_t modes;
    pair_t pairing;
    logic  last;
  } ordering_t;

  logic [LOAD_W-1:0] freq_copy [NUM_MODES_DEF];
  logic [TOL_W-1:0]  tolerance;
  logic              equal_mode;
  ordering_t         awaited_orderings [$];

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  // Print one line per problem and count it.
  task automatic flag_error(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Exact absolute mismatch of one pairing; it never wraps.
  function automatic int unsigned pair_mismatch(input int p, input int q,
                                                input int r, input int s);
    int diff;
    diff = p + q - r - s;
    return (diff < 0) ? -diff : diff;
  endfunction

  // Work out the orderings that pass for one checked quadruplet.
  task automatic match_orderings(input quad_t q);
    int        fa;
    int        fb;
    int        fc;
    int        fd;
    ordering_t o;
    ordering_t hits [$];
    fa = freq_copy[q.a];
    fb = freq_copy[q.b];
    fc = freq_copy[q.c];
    fd = freq_copy[q.d];
    // With the shortcut on, four equal frequencies give the original order once.
    if (equal_mode && fa == fb && fa == fc && fa == fd) begin
      o.modes   = q;
      o.pairing = PAIR_ABCD;
      o.last    = 1'b1;
      awaited_orderings = {awaited_orderings, o};
      return;
    end
    o.last = 1'b0;
    if (pair_mismatch(fa, fb, fc, fd) <= tolerance) begin
      o.modes   = q;
      o.pairing = PAIR_ABCD;
      hits = {hits, o};
    end
    if (pair_mismatch(fa, fd, fc, fb) <= tolerance) begin
      o.modes   = q;
      o.modes.b = q.d;
      o.modes.d = q.b;
      o.pairing = PAIR_ADCB;
      hits = {hits, o};
    end
    if (pair_mismatch(fa, fc, fb, fd) <= tolerance) begin
      o.modes   = q;
      o.modes.b = q.c;
      o.modes.c = q.b;
      o.pairing = PAIR_ACBD;
      hits = {hits, o};
    end
    if (hits.size() > 0) begin
      hits[hits.size()-1].last = 1'b1;
    end
    foreach (hits[i]) begin
      awaited_orderings = {awaited_orderings, hits[i]};
    end
  endtask

  // Compare one result transfer with the oldest awaited ordering.
  task automatic compare_result();
    quad_t     got;
    ordering_t want;
    got = quad_t'(out_tdata);
    if (awaited_orderings.size() == 0) begin
      flag_error($sformatf("result %0d %0d %0d %0d arrived with none awaited",
                           got.a, got.b, got.c, got.d));
      return;
    end
    want = awaited_orderings.pop_front();
    check_field("out_first", got.a, want.modes.a);
    check_field("out_second", got.b, want.modes.b);
    check_field("out_third", got.c, want.modes.c);
    check_field("out_fourth", got.d, want.modes.d);
    check_field("pairing", out_tuser, want.pairing);
    check_field("last", out_tlast, want.last);
  endtask

  // Track register writes, input transfers and result transfers.
  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_orderings.delete();
      tolerance  = '0;
      equal_mode = 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_MATCH_TOLERANCE: tolerance  = cfg_wdata;
          CFG_EQUAL_SHORTCUT:  equal_mode = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser) == OP_LOAD) begin
          freq_copy[in_tdata[IDX_W-1:0]] = in_tdata[IDX_W +: LOAD_W];
        end else begin
          match_orderings(quad_t'(in_tdata[IDX_W+LOAD_W +: 4*IDX_W]));
        end
      end
      if (out_tvalid && out_tready) begin
        compare_result();
      end
    end
    outstanding <= awaited_orderings.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// testbench: stimulus and verdict for the frequency matching quad filter
// Loads the frequency table, checks directed quadruplets at the register
// extremes, then runs random phases of loads and checks under several
// register settings with random idling on both channels. The checker beside
// the filter predicts and compares every result transfer.
// ============================================================================
module testbench;
  import fmqf_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [PAIR_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [TOL_W-1:0]      cfg_wdata  = '0;

  int unsigned error_count;
  int unsigned outstanding;

  // Idle chance on both sides: one in idle_odds+1 per input transfer and per result-side cycle, 0 for none.
  int unsigned idle_odds  = 0;
  int unsigned sink_stall = 0;

  // Table entries loaded so far; checks only name these.
  bit               mode_written [NUM_MODES_DEF];
  logic [IDX_W-1:0] written_modes [$];

  always #4 clk = ~clk;

  frequency_matching_quad_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  quad_filter_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  // Result side: ready drops in random bursts.
  always @(posedge clk) begin
    if (sink_stall != 0) begin
      sink_stall <= sink_stall - 1;
      out_tready <= (sink_stall == 1);
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      sink_stall <= $urandom_range(1, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One input transfer, after an optional idle burst. Valid stays high.
  task automatic send_item(input op_t op, input logic [IDX_W-1:0] load_idx,
                           input logic [LOAD_W-1:0] load_val, input quad_t q);
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-LOAD_W-5*IDX_W){1'b0}}, q, load_val, load_idx};
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD && !mode_written[load_idx]) begin
      mode_written[load_idx] = 1'b1;
      written_modes = {written_modes, load_idx};
    end
  endtask

  // Loads carry random check fields and checks random load fields.
  task automatic load_freq(input logic [IDX_W-1:0] idx, input logic [LOAD_W-1:0] val);
    send_item(OP_LOAD, idx, val, quad_t'(40'({$urandom, $urandom})));
  endtask

  task automatic check_quad(input quad_t q);
    send_item(OP_CHECK, IDX_W'($urandom), LOAD_W'($urandom), q);
  endtask

  // Stop sending and wait until the filter has drained completely.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(input logic [TOL_W-1:0] tol, input logic eq);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_MATCH_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_addr  <= CFG_EQUAL_SHORTCUT;
    cfg_wdata <= {{(TOL_W-1){1'b0}}, eq};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] any_written();
    return written_modes[$urandom_range(0, written_modes.size() - 1)];
  endfunction

  // Mostly checks on loaded entries; loads favor clustered values so that
  // pairings pass often, and some of them rewrite entries already loaded.
  task automatic random_item();
    logic [IDX_W-1:0]  idx;
    logic [LOAD_W-1:0] val;
    quad_t             q;
    if ($urandom_range(0, 3) == 0) begin
      idx = ($urandom_range(0, 1) == 0) ? any_written() : IDX_W'($urandom);
      case ($urandom_range(0, 2))
        0:       val = 16'd1000 + LOAD_W'($urandom_range(0, 24));
        1:       val = 16'hFFFF - LOAD_W'($urandom_range(0, 24));
        default: val = LOAD_W'($urandom);
      endcase
      load_freq(idx, val);
    end else begin
      q.a = any_written();
      q.b = any_written();
      q.c = any_written();
      q.d = any_written();
      check_quad(q);
    end
  endtask

  // Time limit for the whole run.
  initial begin
    #(8 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  // Main stimulus sequence.
  initial begin
    int unsigned      odds_by_phase [5];
    logic [TOL_W-1:0] tol;
    logic             eq;
    odds_by_phase = '{3, 6, 0, 2, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    set_config('0, 1'b0);

    // Directed loads at the value and index extremes.
    load_freq(10'd0, 16'h0000);
    load_freq(10'd1023, 16'hFFFF);
    load_freq(10'h155, 16'h5555);
    load_freq(10'h2AA, 16'hAAAA);
    load_freq(10'd1, 16'hFFFF);
    load_freq(10'd2, 16'h0000);
    load_freq(10'd3, 16'd100);
    load_freq(10'd4, 16'd100);

    // Zero tolerance: widest mismatch, all equal, complements, no match.
    check_quad('{d: 10'd2, c: 10'd1, b: 10'd1023, a: 10'd0});
    check_quad('{d: 10'd4, c: 10'd3, b: 10'd4, a: 10'd3});
    check_quad('{d: 10'd1023, c: 10'd0, b: 10'h2AA, a: 10'h155});
    check_quad('{d: 10'd1023, c: 10'd0, b: 10'd0, a: 10'd0});
    check_quad('{d: 10'h155, c: 10'h2AA, b: 10'd1023, a: 10'd1023});
    settle();

    // Largest tolerance with the equal shortcut on.
    set_config({TOL_W{1'b1}}, 1'b1);
    check_quad('{d: 10'd4, c: 10'd3, b: 10'd4, a: 10'd3});
    check_quad('{d: 10'd2, c: 10'd1, b: 10'd1023, a: 10'd0});
    check_quad('{d: 10'd1, c: 10'd1023, b: 10'd1, a: 10'd1023});
    settle();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       begin tol = TOL_W'($urandom_range(0, 40));     eq = 1'b0; end
        1:       begin tol = '0;                               eq = 1'b1; end
        2:       begin tol = TOL_W'($urandom_range(0, 131071)); eq = 1'($urandom); end
        3:       begin tol = TOL_W'(8);                         eq = 1'b1; end
        default: begin tol = TOL_W'($urandom_range(0, 24));     eq = 1'($urandom); end
      endcase
      set_config(tol, eq);
      idle_odds = odds_by_phase[phase];
      repeat (50) random_item();
      settle();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fmqf_pkg.sv
sv/fmqf_ram.sv
sv/frequency_matching_quad_filter.sv
tb/quad_filter_checker.sv
tb/testbench.sv
